// File: hdl/swrc_pkg.sv
`default_nettype none

package swrc_pkg;

    // Field widths of one request beat and one response beat.
    localparam int OP_W  = 2;
    localparam int CNT_W = 64;
    localparam int WIN_W = 16;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_CNT_W = $clog2(CNT_W);

    // Operation codes on the request channel.
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Command kinds after classification by the front end.
    typedef enum logic [1:0] {
        K_TICK,
        K_ADD,
        K_QUERY,
        K_BAD
    } kind_t;

    // One queued command.
    typedef struct packed {
        kind_t              kind;
        logic [CNT_W-1:0]   count;
        logic [WIN_W-1:0]   win;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SUM,
        S_SUM_END,
        S_DIV,
        S_RESULT
    } state_t;

    // Saturating 64-bit add.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/swrc_ifs.sv
`default_nettype none

// Request channel: one beat carries one operation.
interface swrc_req_if;
    import swrc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CNT_W-1:0]    event_count;
    logic [WIN_W-1:0]    window_seconds;

    modport source (output valid, output operation, output event_count,
                    output window_seconds, input ready);
    modport sink   (input valid, input operation, input event_count,
                    input window_seconds, output ready);
endinterface

// Response channel: one beat per query.
interface swrc_rsp_if;
    import swrc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    rate;
    logic                status;

    modport source (output valid, output rate, output status, input ready);
    modport sink   (input valid, input rate, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/swrc_front.sv
`default_nettype none

module swrc_front #(
    parameter int MAX_SECONDS = 4096
) (
    swrc_req_if.sink        req,
    input  logic            q_full,
    output logic            q_push,
    output swrc_pkg::cmd_t  q_cmd
);
    import swrc_pkg::*;

    localparam logic [WIN_W:0] MAX_WIN = (WIN_W + 1)'(MAX_SECONDS);

    op_t  op;
    logic win_bad;
    logic keep;

    // A beat is taken whenever the queue has room; unused codes are dropped.
    assign req.ready = !q_full;
    assign op        = op_t'(req.operation);
    assign win_bad   = (req.window_seconds == '0) ||
                       ({1'b0, req.window_seconds} > MAX_WIN);

    // Classify the operation into a command kind.
    always_comb
    begin
        q_cmd.count = req.event_count;
        q_cmd.win   = req.window_seconds;
        q_cmd.kind  = K_TICK;
        keep        = 1'b1;
        case (op)
            OP_TICK:  q_cmd.kind = K_TICK;
            OP_ADD:   q_cmd.kind = K_ADD;
            OP_QUERY: q_cmd.kind = win_bad ? K_BAD : K_QUERY;
            default:  keep = 1'b0;
        endcase
    end

    assign q_push = req.valid && !q_full && keep;

endmodule

`default_nettype wire

// File: hdl/swrc_cmd_fifo.sv
`default_nettype none

module swrc_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  swrc_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output swrc_pkg::cmd_t  pop_cmd,
    output logic            empty
);
    import swrc_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    cmd_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    assign full    = (fill_reg == FILL_MAX);
    assign empty   = (fill_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("command queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// File: hdl/swrc_div.sv
`default_nettype none

module swrc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [swrc_pkg::CNT_W-1:0]  dividend,
    input  logic [swrc_pkg::WIN_W-1:0]  divisor,
    output logic                        done,
    output logic [swrc_pkg::CNT_W-1:0]  quotient
);
    import swrc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(CNT_W - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;
    logic [WIN_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       quo_reg, quo_next;
    logic [WIN_W-1:0]       dsr_reg, dsr_next;
    logic [WIN_W:0]         trial;
    logic                   fits;

    // Restoring division: the dividend shifts out at the top while
    // quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[CNT_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? WIN_W'(trial - {1'b0, dsr_reg}) : trial[WIN_W-1:0];
            quo_next  = {quo_reg[CNT_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/swrc_back.sv
`default_nettype none

module swrc_back #(
    parameter int MAX_SECONDS = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  swrc_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    swrc_rsp_if.source      rsp
);
    import swrc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SECONDS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_SECONDS - 1);
    localparam logic [WIN_W:0]    WIN_LAST  = (WIN_W + 1)'(MAX_SECONDS - 1);

    // Bucket ring, no reset; validity is tracked from the slot position.
    logic [CNT_W-1:0]   bucket_mem [MAX_SECONDS];

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               wrapped_reg, wrapped_next;
    logic               zero_ok_reg, zero_ok_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [SLOT_W-1:0]  addr_reg, addr_next;
    logic [SLOT_W-1:0]  left_reg, left_next;
    logic               pend_reg;
    logic [CNT_W-1:0]   sum_reg, sum_next;
    logic               bad_reg, bad_next;
    logic [CNT_W-1:0]   rd_data_reg;
    logic               rd_ok_reg;
    logic               out_vld_reg;
    logic [CNT_W-1:0]   rate_reg;
    logic               status_reg;

    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               rd_ok;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [CNT_W-1:0]   wr_data;
    logic               div_start;
    logic               div_done;
    logic [CNT_W-1:0]   div_quo;
    logic               out_load;
    logic [SLOT_W-1:0]  slot_inc;
    logic [CNT_W-1:0]   bucket_val;
    logic [SLOT_W-1:0]  last_age;

    assign slot_inc   = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
    assign bucket_val = rd_ok_reg ? rd_data_reg : '0;
    assign last_age   = ({1'b0, q_cmd.win} >= WIN_LAST) ? SLOT_LAST : SLOT_W'(q_cmd.win);

    // A bucket holds real data once the ring has wrapped; before that, the
    // slots up to the current one were cleared by ticks, and slot zero is
    // valid once something was written to it.
    assign rd_ok = wrapped_reg ||
                   ((rd_addr == '0) ? zero_ok_reg : (rd_addr <= slot_reg));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.kind)
                        K_ADD:   state_next = S_ADD;
                        K_QUERY: state_next = S_SUM;
                        K_BAD:   state_next = S_RESULT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:     state_next = S_IDLE;
            S_SUM:     state_next = (left_reg == '0) ? S_SUM_END : S_SUM;
            S_SUM_END: state_next = S_DIV;
            S_DIV:     state_next = div_done ? S_RESULT : S_DIV;
            S_RESULT:  state_next = out_load ? S_IDLE : S_RESULT;
            default:   state_next = S_IDLE;
        endcase
    end

    // Control strobes for the queue, the bucket memory and the divider.
    always_comb
    begin
        q_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = slot_reg;
        wr_en     = 1'b0;
        wr_addr   = slot_reg;
        wr_data   = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                q_pop = !q_empty;
                if (!q_empty && q_cmd.kind == K_TICK)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_inc;
                end
                if (!q_empty && q_cmd.kind == K_ADD)
                begin
                    rd_en = 1'b1;
                end
            end
            S_ADD:
            begin
                wr_en   = 1'b1;
                wr_data = sat_add(bucket_val, count_reg);
            end
            S_SUM:
            begin
                rd_en   = 1'b1;
                rd_addr = addr_reg;
            end
            S_SUM_END: div_start = 1'b1;
            S_RESULT:  out_load  = !out_vld_reg || rsp.ready;
            default:   q_pop     = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        slot_next    = slot_reg;
        wrapped_next = wrapped_reg;
        zero_ok_next = zero_ok_reg;
        count_next   = count_reg;
        win_next     = win_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        bad_next     = bad_reg;
        if (q_pop)
        begin
            count_next = q_cmd.count;
            win_next   = q_cmd.win;
            addr_next  = slot_reg;
            left_next  = last_age;
            sum_next   = '0;
            bad_next   = (q_cmd.kind == K_BAD);
            if (q_cmd.kind == K_TICK)
            begin
                slot_next = slot_inc;
                if (slot_inc == '0)
                begin
                    wrapped_next = 1'b1;
                end
            end
        end
        if (state_reg == S_ADD && slot_reg == '0)
        begin
            zero_ok_next = 1'b1;
        end
        if (state_reg == S_SUM)
        begin
            addr_next = (addr_reg == '0) ? SLOT_LAST : addr_reg - 1'b1;
            if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
            end
        end
        // Read data lands in the cycle after its address was issued.
        if (pend_reg)
        begin
            sum_next = sat_add(sum_reg, bucket_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
            zero_ok_reg <= 1'b0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            wrapped_reg <= wrapped_next;
            zero_ok_reg <= zero_ok_next;
            pend_reg    <= (state_reg == S_SUM);
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        win_reg   <= win_next;
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        sum_reg   <= sum_next;
        bad_reg   <= bad_next;
        if (out_load)
        begin
            rate_reg   <= bad_reg ? '0 : div_quo;
            status_reg <= bad_reg;
        end
    end

    // Bucket memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bucket_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bucket_mem[rd_addr];
            rd_ok_reg   <= rd_ok;
        end
    end

    swrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign rsp.valid  = out_vld_reg;
    assign rsp.rate   = rate_reg;
    assign rsp.status = status_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("current slot outside the ring");

    a_pend_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == S_SUM))
        else $error("bucket accumulated without a summing read");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished while the sequencer was not waiting");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && !q_empty))
        else $error("command taken outside idle");

endmodule

`default_nettype wire

// File: hdl/sliding_window_rate_counter.sv
`default_nettype none

// Sliding-window event rate counter.
// The req channel carries one operation per beat: tick (advance one second
// and clear the bucket that leaves the window), add (add event_count to the
// current second, saturating) or query (rate over window_seconds). Code 3 is
// taken and dropped. The rsp channel returns one beat per query: rate is the
// saturated bucket sum over ages 0..window_seconds (capped at MAX_SECONDS-1)
// divided by window_seconds; status is set, with rate 0, for a window of zero
// or beyond MAX_SECONDS.
// Beats enter a command queue of QUEUE_DEPTH entries, so req keeps accepting
// while a query is being worked on, until the queue fills.
// In the back end, a tick clears the next bucket as it is taken, and an add
// reads, then writes, the bucket memory. A query takes the command, reads
// buckets of ages 0..last_age on the single memory read port, closes the
// sum, runs the bit-serial divider (64 quotient bits, then its done flag)
// and loads the response register. An invalid query goes straight to
// loading the response; every command is registered in the queue first.
// Reset empties the queue and starts at slot zero with all buckets reading
// zero; no clearing pass is needed. When rsp stalls, the response register
// holds its beat and the back end waits once its next response is ready, while the queue keeps filling.
module sliding_window_rate_counter #(
    parameter int MAX_SECONDS = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    swrc_req_if.sink    req,
    swrc_rsp_if.source  rsp
);
    import swrc_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    cmd_t   push_cmd;
    cmd_t   pop_cmd;

    swrc_front #(
        .MAX_SECONDS (MAX_SECONDS)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    swrc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    swrc_back #(
        .MAX_SECONDS (MAX_SECONDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swrc_pkg::*;

    localparam int WINDOW_MAX    = 4096;
    localparam int SLOT_W        = $clog2(WINDOW_MAX);
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 32;
    localparam int REPORT_LIMIT  = 10;

    // One response beat as the checker expects it.
    typedef struct packed {
        logic [CNT_W-1:0] rate;
        logic             status;
    } rate_result_t;

    logic clk;
    logic rst_n;

    swrc_req_if req_ch ();
    swrc_rsp_if rsp_ch ();

    sliding_window_rate_counter #(
        .MAX_SECONDS(WINDOW_MAX)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the per-second totals and the current second.
    logic [CNT_W-1:0]  second_totals [WINDOW_MAX];
    logic [SLOT_W-1:0] slot_now;

    rate_result_t pending_rates [$];
    int           mismatch_count;
    bit           idle_enable;
    int           hold_requests;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W-1:0] s;
        s = a + b;
        if (s < a)
        begin
            s = '1;
        end
        return s;
    endfunction

    function automatic void report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endfunction

    // Update the shadow state for one accepted beat and queue the rate it produces.
    function automatic void predict_beat(input op_t op, input logic [CNT_W-1:0] count,
                                         input logic [WIN_W-1:0] win);
        rate_result_t      res;
        logic [CNT_W-1:0]  total;
        logic [SLOT_W-1:0] slot;
        int                last_age;
        case (op)
            OP_TICK:
            begin
                slot_now = slot_now + 1'b1;
                second_totals[slot_now] = '0;
            end
            OP_ADD:
            begin
                second_totals[slot_now] = sat_sum(second_totals[slot_now], count);
            end
            OP_QUERY:
            begin
                if (win == 0 || win > WINDOW_MAX)
                begin
                    res.rate   = '0;
                    res.status = 1'b1;
                end
                else
                begin
                    // Ages 0..win are summed, but only what the ring still holds.
                    last_age = (win > WINDOW_MAX - 1) ? WINDOW_MAX - 1 : int'(win);
                    total = '0;
                    slot  = slot_now;
                    for (int k = 0; k <= last_age; k++)
                    begin
                        total = sat_sum(total, second_totals[slot]);
                        slot  = slot - 1'b1;
                    end
                    res.rate   = total / {{(CNT_W-WIN_W){1'b0}}, win};
                    res.status = 1'b0;
                end
                pending_rates.insert(pending_rates.size(), res);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one beat, starting and ending at a falling edge; valid stays high afterward.
    task automatic send_beat(input op_t op, input logic [CNT_W-1:0] count,
                             input logic [WIN_W-1:0] win);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= op;
        req_ch.event_count    <= count;
        req_ch.window_seconds <= win;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        predict_beat(op, count, win);
        @(negedge clk);
    endtask

    // Stop offering and wait until every queued rate has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rates.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [WIN_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return WIN_W'($urandom_range(1, 40));
        end
        if (r < 85)
        begin
            return WIN_W'($urandom_range(41, WINDOW_MAX));
        end
        if (r < 88)
        begin
            return WIN_W'(WINDOW_MAX - $urandom_range(0, 1));
        end
        if (r < 93)
        begin
            return '0;
        end
        return WIN_W'($urandom_range(WINDOW_MAX + 1, 65535));
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return CNT_W'($urandom_range(0, 5000));
        end
        if (r < 92)
        begin
            return {$urandom, $urandom} >> $urandom_range(1, 63);
        end
        return {$urandom, $urandom};
    endfunction

    // Invalid windows, an empty-ring query and the unused operation code.
    task automatic test_invalid_windows();
        send_beat(OP_QUERY, '0, '0);
        send_beat(OP_QUERY, '0, WIN_W'(WINDOW_MAX + 1));
        send_beat(OP_QUERY, '1, '1);
        send_beat(OP_QUERY, '0, 16'h8000);
        send_beat(OP_QUERY, '0, 16'd1);
        send_beat(OP_NONE, '1, 16'd1);
        send_beat(OP_NONE, {$urandom, $urandom}, WIN_W'($urandom));
    endtask

    // A bucket that overflows must stick at the maximum.
    task automatic test_add_saturation();
        send_beat(OP_ADD, '1, '0);
        send_beat(OP_ADD, 64'd1, '0);
        send_beat(OP_QUERY, '0, 16'd1);
        send_beat(OP_QUERY, '0, 16'd2);
    endtask

    // Two half-range buckets overflow the windowed sum; also the full-ring windows.
    task automatic test_sum_saturation();
        send_beat(OP_TICK, '0, '0);
        send_beat(OP_ADD, 64'h8000_0000_0000_0000, '0);
        send_beat(OP_TICK, '1, '1);
        send_beat(OP_ADD, 64'h8000_0000_0000_0005, '0);
        send_beat(OP_ADD, '0, '0);
        send_beat(OP_QUERY, '0, 16'd3);
        send_beat(OP_QUERY, '0, WIN_W'(WINDOW_MAX));
        send_beat(OP_QUERY, '0, WIN_W'(WINDOW_MAX - 1));
    endtask

    // Random mix of ticks, adds, queries and the unused code.
    task automatic test_random_mix(input int n_beats);
        int pick;
        for (int i = 0; i < n_beats; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_beat(OP_ADD, pick_count(), WIN_W'($urandom));
            end
            else if (pick < 65)
            begin
                send_beat(OP_TICK, {$urandom, $urandom}, WIN_W'($urandom));
            end
            else if (pick < 95)
            begin
                send_beat(OP_QUERY, {$urandom, $urandom}, pick_window());
            end
            else
            begin
                send_beat(OP_NONE, {$urandom, $urandom}, WIN_W'($urandom));
            end
        end
    endtask

    // The receiver holds off long enough for the command queue to fill up.
    task automatic test_response_hold();
        hold_requests++;
        for (int i = 0; i < 12; i++)
        begin
            send_beat(OP_ADD, CNT_W'($urandom_range(0, 300)), '0);
            send_beat(OP_QUERY, '0, WIN_W'($urandom_range(1, 8)));
        end
        wait_drained();
    endtask

    // Response side: random stalls, plus the long hold-off when one is asked for.
    initial
    begin : drive_response_ready
        int hold_left;
        int stall_left;
        int holds_done;
        hold_left  = 0;
        stall_left = 0;
        holds_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each response beat with the oldest predicted rate.
    always @(posedge clk)
    begin : check_rates
        rate_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_rates.size() == 0)
            begin
                report_error($sformatf("unexpected beat: rate %0d status %0d",
                                       rsp_ch.rate, rsp_ch.status));
            end
            else
            begin
                want = pending_rates.pop_front();
                if (rsp_ch.rate !== want.rate)
                begin
                    report_error($sformatf("rate mismatch: expected %0d, got %0d",
                                           want.rate, rsp_ch.rate));
                end
                if (rsp_ch.status !== want.status)
                begin
                    report_error($sformatf("status mismatch: expected %0d, got %0d",
                                           want.status, rsp_ch.status));
                end
            end
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin : run_tests
        mismatch_count = 0;
        hold_requests  = 0;
        idle_enable    = 1'b1;
        slot_now       = '0;
        foreach (second_totals[i])
        begin
            second_totals[i] = '0;
        end
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_TICK;
        req_ch.event_count    = '0;
        req_ch.window_seconds = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_invalid_windows();
        test_add_saturation();
        test_sum_saturation();
        test_random_mix(700);
        test_response_hold();

        // The tail runs with neither side idling.
        idle_enable = 1'b0;
        test_random_mix(200);
        wait_drained();

        if (mismatch_count == 0 && pending_rates.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hdl/swrc_pkg.sv
hdl/swrc_ifs.sv
hdl/swrc_front.sv
hdl/swrc_cmd_fifo.sv
hdl/swrc_div.sv
hdl/swrc_back.sv
hdl/sliding_window_rate_counter.sv
test/tb.sv
